>>> design/assert_macros.svh
// assertion macros used by the rtl file pvd_queue
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PVD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error("%m");
`define PVD_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error("%m");
`else
`define PVD_ASSERT(lbl, prop)
`define PVD_NEVER(lbl, expr)
`endif
`endif

>>> design/pvd_pkg.sv
// types, constants and the range table of the pvd embedder
// no dependencies
package pvd_pkg;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int InDataW  = 32;
  localparam int OutDataW = 24;
  localparam int OutUserW = 2;

  typedef struct packed {
    logic [7:0] g0;
    logic [7:0] g1;
    logic [6:0] secret;
    logic [2:0] nbits;
    logic [7:0] lower;
    logic       neg;
    logic       embed;
  } pair_t;

  typedef struct packed {
    logic  valid;
    pair_t data;
  } q_beat_t;

  typedef struct packed {
    logic [2:0] nbits;
    logic [7:0] lower;
  } range_t;

  function automatic range_t pick_range(logic [7:0] mag);
    range_t r;
    if (mag[7]) begin
      r = '{nbits: 3'd7, lower: 8'd128};
    end else if (mag[6]) begin
      r = '{nbits: 3'd6, lower: 8'd64};
    end else if (mag[5]) begin
      r = '{nbits: 3'd5, lower: 8'd32};
    end else if (mag[4]) begin
      r = '{nbits: 3'd4, lower: 8'd16};
    end else if (mag[3]) begin
      r = '{nbits: 3'd3, lower: 8'd8};
    end else begin
      r = '{nbits: 3'd3, lower: 8'd0};
    end
    return r;
  endfunction

endpackage

>>> design/pvd_front.sv
// front end: accepts pairs, picks the range and tracks the stop flag
// depends on pvd_pkg
module pvd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // first_value[7:0], second_value[15:8], secret_bits[22:16], bits_ready[25:23]
  input  logic [pvd_pkg::InDataW-1:0]  s_axis_tdata_i,
  // new_image
  input  logic                         s_axis_tuser_i,
  input  logic                         q_full_i,
  output pvd_pkg::q_beat_t             q_push_o
);
  import pvd_pkg::*;

  logic       stopped_q, stopped_d;
  logic       accept;
  logic [7:0] g0, g1;
  logic [6:0] secret;
  logic [2:0] ready;
  logic [8:0] diff;
  logic [7:0] mag;
  logic       stop_eff;
  range_t     rng;
  logic       short;

  assign s_axis_tready_o = !q_full_i;
  assign accept = s_axis_tvalid_i && !q_full_i;

  assign g0     = s_axis_tdata_i[7:0];
  assign g1     = s_axis_tdata_i[15:8];
  assign secret = s_axis_tdata_i[22:16];
  assign ready  = s_axis_tdata_i[25:23];

  always_comb begin
    diff     = {1'b0, g1} - {1'b0, g0};
    mag      = diff[8] ? 8'(-diff) : diff[7:0];
    rng      = pick_range(mag);
    stop_eff = s_axis_tuser_i ? 1'b0 : stopped_q;
    short    = ready < rng.nbits;
    stopped_d = stopped_q;
    if (accept) begin
      stopped_d = stop_eff || short;
    end
    q_push_o.valid        = accept;
    q_push_o.data.g0      = g0;
    q_push_o.data.g1      = g1;
    q_push_o.data.secret  = secret;
    q_push_o.data.nbits   = rng.nbits;
    q_push_o.data.lower   = rng.lower;
    q_push_o.data.neg     = diff[8];
    q_push_o.data.embed   = !stop_eff && !short;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q <= 1'b0;
    end else begin
      stopped_q <= stopped_d;
    end
  end

endmodule

>>> design/pvd_queue.sv
// short queue of classified pairs between front and back
// depends on pvd_pkg and assert_macros.svh
`include "assert_macros.svh"
module pvd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pvd_pkg::q_beat_t push_i,
  output logic             full_o,
  output pvd_pkg::q_beat_t head_o,
  input  logic             pop_i
);
  import pvd_pkg::*;

  pair_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign full_o       = cnt_q == QCntW'(QDepth);
  assign head_o.valid = cnt_q != '0;
  assign head_o.data  = mem_q[rd_ptr_q];
  assign push         = push_i.valid && !full_o;
  assign pop          = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCntW'(push) - QCntW'(pop);
    end
  end

  `PVD_NEVER(a_no_overflow, cnt_q > QCntW'(QDepth))
  `PVD_NEVER(a_push_when_full, push_i.valid && full_o)
  `PVD_NEVER(a_pop_when_empty, pop_i && !head_o.valid)
  `PVD_ASSERT(a_count_track, 1'b1 |=> cnt_q == $past(cnt_q) + QCntW'($past(push)) - QCntW'($past(pop)))

endmodule

>>> design/pvd_back.sv
// back end: forms the new difference, splits it and registers the result
// depends on pvd_pkg
module pvd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pvd_pkg::q_beat_t             head_i,
  output logic                         pop_o,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // first_out[7:0], second_out[15:8], bits_used[18:16]
  output logic [pvd_pkg::OutDataW-1:0] m_axis_tdata_o,
  // embedded[0], wrapped[1]
  output logic [pvd_pkg::OutUserW-1:0] m_axis_tuser_o
);
  import pvd_pkg::*;

  pair_t              p;
  logic               out_valid_q;
  logic [OutDataW-1:0] data_q, data_d;
  logic [OutUserW-1:0] user_q, user_d;
  logic signed [8:0]  diff;
  logic [6:0]         sh;
  logic [7:0]         val;
  logic signed [9:0]  dec, m, mr, down, up;
  logic signed [10:0] n0, n1;
  logic               wrap;

  assign p     = head_i.data;
  assign pop_o = head_i.valid && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    diff = $signed({1'b0, p.g1}) - $signed({1'b0, p.g0});
    sh   = p.secret >> (3'd7 - p.nbits);
    val  = {1'b0, sh} + p.lower;
    dec  = p.neg ? -$signed({2'b00, val}) : $signed({2'b00, val});
    m    = dec - $signed({diff[8], diff});
    mr   = m + $signed({9'b0, m[9]});
    down = mr >>> 1;
    up   = m - down;
    n0   = $signed({3'b000, p.g0}) - $signed({up[9], up});
    n1   = $signed({3'b000, p.g1}) + $signed({down[9], down});
    wrap = (|n0[10:8]) || (|n1[10:8]);
    if (p.embed) begin
      data_d = {5'b0, p.nbits, n1[7:0], n0[7:0]};
      user_d = {wrap, 1'b1};
    end else begin
      data_d = {5'b0, 3'b000, p.g1, p.g0};
      user_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      user_q <= user_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = user_q;

endmodule

>>> design/pvd_stego_embed.sv
// pvd embedder top level: one pair per cycle sustained while the output is not stalled,
// each result held first in a queue entry, then in the output register
// ready drops only when the two-entry queue between front and back is full
// reset clears the stop flag, the queue and the output valid
// depends on pvd_pkg, pvd_front, pvd_queue, pvd_back
module pvd_stego_embed (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // first_value[7:0], second_value[15:8], secret_bits[22:16], bits_ready[25:23]
  input  logic [pvd_pkg::InDataW-1:0]  s_axis_tdata_i,
  // new_image
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // first_out[7:0], second_out[15:8], bits_used[18:16]
  output logic [pvd_pkg::OutDataW-1:0] m_axis_tdata_o,
  // embedded[0], wrapped[1]
  output logic [pvd_pkg::OutUserW-1:0] m_axis_tuser_o
);
  import pvd_pkg::*;

  q_beat_t push, head;
  logic    full, pop;

  pvd_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .q_full_i (full),
    .q_push_o (push)
  );

  pvd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  pvd_back u_back (
    .clk_i,
    .rst_ni,
    .head_i (head),
    .pop_o  (pop),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

endmodule
